// ----- design/dlle_pkg.sv -----
// shared constants and types for the doubly linked list engine
// no dependencies: every other file of the block imports this package

package dlle_pkg;

   // default sizes handed to the top level parameters
   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 8;

   // fixed port widths
   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 8;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   // request modes
   localparam mode_type MODE_PREPEND     = 3'd0;
   localparam mode_type MODE_APPEND      = 3'd1;
   localparam mode_type MODE_REMOVE_HEAD = 3'd2;
   localparam mode_type MODE_REMOVE_TAIL = 3'd3;
   localparam mode_type MODE_INSERT_AT   = 3'd4;
   localparam mode_type MODE_SEARCH      = 3'd5;

   // result status codes
   localparam status_type STATUS_DONE     = 2'd0;
   localparam status_type STATUS_EMPTY    = 2'd1;
   localparam status_type STATUS_FULL     = 2'd2;
   localparam status_type STATUS_PAST_END = 2'd3;

   // value returned by remove head on an empty list
   localparam logic [VALUE_W-1:0] EMPTY_MARK = 8'd32;

endpackage

// ----- design/doubly_linked_list_engine.sv -----
// top level of the doubly linked list engine: sequencer around one list memory
// depends on dlle_pkg

// One transaction is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with rsp_valid, and cannot be held off. Requests
// that need no memory access (list full, list empty, position past end, unused modes)
// answer in the cycle after acceptance. Remove head or tail reads the end entry and
// unlinks it; prepend and append allocate an entry, write it and patch a neighbour;
// insert before position p first walks to p; a search compares element by element up
// to a hit or the tail. Reusing a freed entry first reads it off the recycled list.
// The single list memory has one synchronous read and one write per cycle, so a walk
// follows one link each cycle. Entries never used are handed out from a fill count,
// so there is no clearing pass after reset. busy stays high until the cycle in which
// the result is shown; a new transaction can be accepted in that same cycle.

module doubly_linked_list_engine
   import dlle_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]    req_position,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_removed_value,
   output logic                rsp_found,
   output logic [COUNT_W-1:0]  rsp_element_count
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (CW > POS_W) ? CW : POS_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_WALK     = 4'd1;
   localparam logic [3:0] S_SEARCH   = 4'd2;
   localparam logic [3:0] S_TAKE     = 4'd3;
   localparam logic [3:0] S_ALLOC    = 4'd4;
   localparam logic [3:0] S_ALLOC_RD = 4'd5;
   localparam logic [3:0] S_WR0      = 4'd6;
   localparam logic [3:0] S_WR1      = 4'd7;
   localparam logic [3:0] S_WR2      = 4'd8;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] data;
      logic [IW-1:0]         nxt;
      logic [IW-1:0]         prv;
   } entry_type;

   // list memory and its ports
   entry_type list_mem [CAPACITY];
   entry_type rd_word_ff;
   entry_type wr_word;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic          wr_data_en;
   logic          wr_nxt_en;
   logic          wr_prv_en;

   // control state
   logic [3:0]    state_ff,  state_in;
   logic [IW-1:0] head_ff,   head_in;
   logic [IW-1:0] tail_ff,   tail_in;
   logic [IW-1:0] rec_ff,    rec_in;
   logic [CW-1:0] count_ff,  count_in;
   logic [CW-1:0] fresh_ff,  fresh_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // transaction payload
   mode_type              mode_ff,   mode_in;
   logic [DATA_WIDTH-1:0] value_ff,  value_in;
   logic [POS_W-1:0]      pos_ff,    pos_in;
   logic [IW-1:0]         cur_ff,    cur_in;
   logic [IW-1:0]         before_ff, before_in;
   logic [IW-1:0]         slot_ff,   slot_in;
   logic [SW-1:0]         step_ff,   step_in;
   status_type            rsp_status_ff,  rsp_status_in;
   logic [VALUE_W-1:0]    rsp_removed_ff, rsp_removed_in;
   logic                  rsp_found_ff,   rsp_found_in;
   logic [COUNT_W-1:0]    rsp_count_ff,   rsp_count_in;

   logic          list_full;
   logic          list_empty;
   logic          list_single;
   logic [SW-1:0] step_inc;
   logic [CW-1:0] count_inc;
   logic [CW-1:0] count_dec;

   assign list_full   = (count_ff == CW'(CAPACITY));
   assign list_empty  = (count_ff == '0);
   assign list_single = (count_ff == CW'(1));
   assign step_inc    = step_ff + SW'(1);
   assign count_inc   = count_ff + CW'(1);
   assign count_dec   = count_ff - CW'(1);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      rec_in         = rec_ff;
      count_in       = count_ff;
      fresh_in       = fresh_ff;
      mode_in        = mode_ff;
      value_in       = value_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      before_in      = before_ff;
      slot_in        = slot_ff;
      step_in        = step_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;
      rd_addr        = cur_ff;
      wr_addr        = slot_ff;
      wr_word        = '0;
      wr_data_en     = 1'b0;
      wr_nxt_en      = 1'b0;
      wr_prv_en      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in        = req_mode;
               value_in       = DATA_WIDTH'(req_value);
               pos_in         = req_position;
               step_in        = '0;
               rsp_status_in  = STATUS_DONE;
               rsp_removed_in = '0;
               rsp_found_in   = 1'b0;
               rsp_count_in   = COUNT_W'(count_ff);
               case (req_mode)
                  MODE_PREPEND, MODE_APPEND: begin
                     if (list_full) begin
                        rsp_status_in = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  MODE_REMOVE_HEAD: begin
                     if (list_empty) begin
                        rsp_status_in  = STATUS_EMPTY;
                        rsp_removed_in = EMPTY_MARK;
                        rsp_valid_in   = 1'b1;
                     end else begin
                        cur_in   = head_ff;
                        rd_addr  = head_ff;
                        state_in = S_TAKE;
                     end
                  end
                  MODE_REMOVE_TAIL: begin
                     if (list_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        cur_in   = tail_ff;
                        rd_addr  = tail_ff;
                        state_in = S_TAKE;
                     end
                  end
                  MODE_INSERT_AT: begin
                     if (list_full) begin
                        rsp_status_in = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (req_position == '0) begin
                        // position zero goes in at the head
                        mode_in  = MODE_PREPEND;
                        state_in = S_ALLOC;
                     end else if (SW'(req_position) >= SW'(count_ff)) begin
                        rsp_status_in = STATUS_PAST_END;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        cur_in   = head_ff;
                        rd_addr  = head_ff;
                        state_in = S_WALK;
                     end
                  end
                  MODE_SEARCH: begin
                     if (list_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        cur_in   = head_ff;
                        rd_addr  = head_ff;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         // follow one forward link per cycle up to the target position
         S_WALK: begin
            cur_in = rd_word_ff.nxt;
            if (step_inc == SW'(pos_ff)) begin
               before_in = cur_ff;
               state_in  = S_ALLOC;
            end else begin
               rd_addr = rd_word_ff.nxt;
               step_in = step_inc;
            end
         end

         // compare one element per cycle, stop on a hit or at the tail
         S_SEARCH: begin
            if (rd_word_ff.data == value_ff) begin
               rsp_found_in = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (step_inc == SW'(count_ff)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cur_in  = rd_word_ff.nxt;
               rd_addr = rd_word_ff.nxt;
               step_in = step_inc;
            end
         end

         // unlink head or tail and push its entry on the recycled list
         S_TAKE: begin
            if (mode_ff == MODE_REMOVE_HEAD) begin
               rsp_removed_in = VALUE_W'(rd_word_ff.data);
               head_in        = list_single ? '0 : rd_word_ff.nxt;
               tail_in        = list_single ? '0 : tail_ff;
            end else begin
               head_in = list_single ? '0 : head_ff;
               tail_in = list_single ? '0 : rd_word_ff.prv;
            end
            wr_addr      = cur_ff;
            wr_word.nxt  = rec_ff;
            wr_nxt_en    = 1'b1;
            rec_in       = cur_ff;
            count_in     = count_dec;
            rsp_count_in = COUNT_W'(count_dec);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         // take a never used entry, else pop the recycled list
         S_ALLOC: begin
            if (fresh_ff != CW'(CAPACITY)) begin
               slot_in  = fresh_ff[IW-1:0];
               fresh_in = fresh_ff + CW'(1);
               state_in = S_WR0;
            end else begin
               rd_addr  = rec_ff;
               state_in = S_ALLOC_RD;
            end
         end

         S_ALLOC_RD: begin
            slot_in  = rec_ff;
            rec_in   = rd_word_ff.nxt;
            state_in = S_WR0;
         end

         // write the new entry with its links
         S_WR0: begin
            wr_addr      = slot_ff;
            wr_word.data = value_ff;
            wr_data_en   = 1'b1;
            wr_nxt_en    = 1'b1;
            wr_prv_en    = 1'b1;
            case (mode_ff)
               MODE_PREPEND: begin
                  wr_word.nxt = head_ff;
               end
               MODE_APPEND: begin
                  wr_word.prv = tail_ff;
               end
               default: begin
                  wr_word.nxt = cur_ff;
                  wr_word.prv = before_ff;
               end
            endcase
            state_in = S_WR1;
         end

         // patch the neighbour that now points at the new entry
         S_WR1: begin
            wr_word.nxt = slot_ff;
            wr_word.prv = slot_ff;
            case (mode_ff)
               MODE_PREPEND: begin
                  wr_addr   = head_ff;
                  wr_prv_en = !list_empty;
                  head_in   = slot_ff;
                  if (list_empty) begin
                     tail_in = slot_ff;
                  end
                  count_in     = count_inc;
                  rsp_count_in = COUNT_W'(count_inc);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               MODE_APPEND: begin
                  wr_addr   = tail_ff;
                  wr_nxt_en = !list_empty;
                  tail_in   = slot_ff;
                  if (list_empty) begin
                     head_in = slot_ff;
                  end
                  count_in     = count_inc;
                  rsp_count_in = COUNT_W'(count_inc);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               default: begin
                  wr_addr   = before_ff;
                  wr_nxt_en = 1'b1;
                  state_in  = S_WR2;
               end
            endcase
         end

         S_WR2: begin
            wr_addr      = cur_ff;
            wr_word.prv  = slot_ff;
            wr_prv_en    = 1'b1;
            count_in     = count_inc;
            rsp_count_in = COUNT_W'(count_inc);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // list memory: one write with field enables, one registered read
   always_ff @(posedge clock) begin
      if (wr_data_en) begin
         list_mem[wr_addr].data <= wr_word.data;
      end
      if (wr_nxt_en) begin
         list_mem[wr_addr].nxt <= wr_word.nxt;
      end
      if (wr_prv_en) begin
         list_mem[wr_addr].prv <= wr_word.prv;
      end
      rd_word_ff <= list_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rec_ff       <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rec_ff       <= rec_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      value_ff       <= value_in;
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      before_ff      <= before_in;
      slot_ff        <= slot_in;
      step_ff        <= step_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

// ----- design/dlle_checker.sv -----
// port level checks for the doubly linked list engine, bound to its top level
// depends on dlle_pkg and doubly_linked_list_engine

module dlle_checker
   import dlle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [VALUE_W-1:0]  rsp_removed_value,
   input logic                rsp_found,
   input logic [COUNT_W-1:0]  rsp_element_count
);

   // a result is only shown once the engine is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // busy only rises on an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // an empty report leaves no elements
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> (rsp_element_count == '0))
      else $error("empty status with elements held");

   // a full report means the list holds its capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL)
         |-> (rsp_element_count == COUNT_W'(CAPACITY)))
      else $error("full status below capacity");

   // a search hit is a plain completion with nothing removed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found
         |-> (rsp_status == STATUS_DONE) && (rsp_removed_value == '0))
      else $error("found flag with wrong status or value");

endmodule

bind doubly_linked_list_engine dlle_checker #(
   .CAPACITY (CAPACITY)
) u_dlle_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_found         (rsp_found),
   .rsp_element_count (rsp_element_count)
);

// ----- tb/doubly_linked_list_engine_test.sv -----
// self-checking testbench for the doubly linked list engine: directed and random list traffic
// depends on dlle_pkg and doubly_linked_list_engine; keeps its own copy of the list contents

`timescale 1ns / 100ps

module doubly_linked_list_engine_test;
   import dlle_pkg::*;

   // modes with no operation behind them
   localparam mode_type MODE_UNUSED_LO = 3'd6;
   localparam mode_type MODE_UNUSED_HI = 3'd7;

   localparam int ITEMS_PER_PHASE = 610;
   localparam int STRETCH         = 120;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 100;
   localparam int MAX_PRINTED     = 40;

   typedef struct packed {
      mode_type           mode;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } list_request_type;

   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   removed;
      logic                 found;
      logic [COUNT_W-1:0]   count;
   } list_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [MODE_W-1:0]   req_mode     = '0;
   logic [VALUE_W-1:0]  req_value    = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_removed_value;
   logic                rsp_found;
   logic [COUNT_W-1:0]  rsp_element_count;

   list_request_type   requests_queued[$];
   list_outcome_type   outcomes_due[$];
   logic [VALUE_W-1:0] held_values[$];
   int                 sender_idle_pct = 36;
   int                 mismatches = 0;

   doubly_linked_list_engine dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_found         (rsp_found),
      .rsp_element_count (rsp_element_count)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < MAX_PRINTED)
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // applies one transaction to the list copy and returns the result it should give
   function automatic list_outcome_type apply_request(mode_type m, logic [VALUE_W-1:0] v,
                                                      logic [POS_W-1:0] p);
      list_outcome_type o;
      int               n;
      o = '0;
      o.status = STATUS_DONE;
      n = held_values.size();
      case (m)
         MODE_PREPEND: begin
            if (n >= CAPACITY_DEF) o.status = STATUS_FULL;
            else held_values.push_front(v);
         end
         MODE_APPEND: begin
            if (n >= CAPACITY_DEF) o.status = STATUS_FULL;
            else held_values.push_back(v);
         end
         MODE_REMOVE_HEAD: begin
            if (n == 0) begin
               o.status  = STATUS_EMPTY;
               o.removed = EMPTY_MARK;
            end else begin
               o.removed = held_values.pop_front();
            end
         end
         MODE_REMOVE_TAIL: begin
            if (n == 0) o.status = STATUS_EMPTY;
            else void'(held_values.pop_back());
         end
         MODE_INSERT_AT: begin
            // full wins over the position check; position zero always goes to the head
            if (n >= CAPACITY_DEF) o.status = STATUS_FULL;
            else if (p == 0) held_values.push_front(v);
            else if (int'(p) >= n) o.status = STATUS_PAST_END;
            else held_values.insert(int'(p), v);
         end
         MODE_SEARCH: begin
            if (n == 0) o.status = STATUS_EMPTY;
            else foreach (held_values[i]) if (held_values[i] == v) o.found = 1'b1;
         end
         default: ;
      endcase
      o.count = COUNT_W'(held_values.size());
      return o;
   endfunction

   // random transaction, biased towards filling or draining the list
   function automatic list_request_type random_request(bit growing);
      list_request_type r;
      int               roll;
      int               n;
      n = held_values.size();
      roll = $urandom_range(99);
      r.value    = VALUE_W'($urandom_range(255));
      r.position = POS_W'($urandom_range(63));
      if (roll < 2) begin
         r.mode = (roll == 0) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
      end else if (roll < 14) begin
         r.mode = MODE_SEARCH;
         // mostly look for something that is held
         if (n > 0 && $urandom_range(2) != 0) r.value = held_values[$urandom_range(n - 1)];
      end else if (growing ? roll < 86 : roll < 40) begin
         case ($urandom_range(2))
            0: r.mode = MODE_PREPEND;
            1: r.mode = MODE_APPEND;
            default: begin
               r.mode = MODE_INSERT_AT;
               if ($urandom_range(3) != 0)
                  r.position = POS_W'($urandom_range(n > 63 ? 63 : n));
            end
         endcase
      end else begin
         r.mode = $urandom_range(1) ? MODE_REMOVE_HEAD : MODE_REMOVE_TAIL;
      end
      return r;
   endfunction

   // driver: offers the oldest queued transaction, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (requests_queued.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
         start        <= 1'b1;
         req_mode     <= requests_queued[0].mode;
         req_value    <= requests_queued[0].value;
         req_position <= requests_queued[0].position;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: checks shown results and predicts each accepted transaction
   always @(posedge clock) begin
      list_outcome_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch("result with no transaction outstanding", rsp_status, 0);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_removed_value !== want.removed)
                  report_mismatch("removed value", rsp_removed_value, want.removed);
               if (rsp_found !== want.found)
                  report_mismatch("found flag", rsp_found, want.found);
               if (rsp_element_count !== want.count)
                  report_mismatch("element count", rsp_element_count, want.count);
            end
         end
         if (start && !busy) begin
            outcomes_due.push_back(apply_request(req_mode, req_value, req_position));
            void'(requests_queued.pop_front());
         end
      end
   end

   // stimulus and end of run
   initial begin
      int phase;
      int k;
      int spin;

      // directed: empty-list cases, head, tail and position inserts, searches, unused modes, removes
      requests_queued.push_back('{MODE_REMOVE_HEAD, 8'h00, 6'd0});
      requests_queued.push_back('{MODE_REMOVE_TAIL, 8'hFF, 6'd63});
      requests_queued.push_back('{MODE_SEARCH,      8'h00, 6'd0});
      requests_queued.push_back('{MODE_INSERT_AT,   8'h11, 6'd63});
      requests_queued.push_back('{MODE_INSERT_AT,   8'hFF, 6'd0});
      requests_queued.push_back('{MODE_INSERT_AT,   8'h00, 6'd1});
      requests_queued.push_back('{MODE_PREPEND,     8'h00, 6'd0});
      requests_queued.push_back('{MODE_APPEND,      8'hFF, 6'd63});
      requests_queued.push_back('{MODE_INSERT_AT,   8'hA5, 6'd1});
      requests_queued.push_back('{MODE_INSERT_AT,   8'h5A, 6'd3});
      requests_queued.push_back('{MODE_INSERT_AT,   8'h77, 6'd5});
      requests_queued.push_back('{MODE_SEARCH,      8'hA5, 6'd0});
      requests_queued.push_back('{MODE_SEARCH,      8'h5A, 6'd63});
      requests_queued.push_back('{MODE_SEARCH,      8'h7E, 6'd0});
      requests_queued.push_back('{MODE_UNUSED_LO,   8'hFF, 6'd63});
      requests_queued.push_back('{MODE_UNUSED_HI,   8'h00, 6'd0});
      requests_queued.push_back('{MODE_REMOVE_TAIL, 8'h00, 6'd0});
      requests_queued.push_back('{MODE_REMOVE_HEAD, 8'h00, 6'd0});
      requests_queued.push_back('{MODE_REMOVE_HEAD, 8'h00, 6'd0});
      requests_queued.push_back('{MODE_REMOVE_TAIL, 8'h00, 6'd0});
      requests_queued.push_back('{MODE_REMOVE_HEAD, 8'h00, 6'd0});
      requests_queued.push_back('{MODE_REMOVE_TAIL, 8'h00, 6'd0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // random: three phases with different sender idle rates, alternating fill and drain stretches
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 47 : 0;
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            do @(negedge clock); while (requests_queued.size() >= 2);
            requests_queued.push_back(random_request(((k / STRETCH) % 2) == 0));
         end
      end

      // drain, then allow for the longest walk
      for (spin = 0; spin < DRAIN_LIMIT &&
                     (requests_queued.size() != 0 || outcomes_due.size() != 0); spin++)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (outcomes_due.size() != 0)
         report_mismatch("results never shown", outcomes_due.size(), 0);

      if (mismatches == 0)
         $display("** doubly_linked_list_engine: PASSED **");
      else
         $display("** doubly_linked_list_engine: FAILED **");
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("** doubly_linked_list_engine: FAILED **");
      $finish;
   end

endmodule
